[rtl/core/stt_pkg.sv]
// Shared types, constants and lexer step functions for the source text tokenizer.
`default_nettype none
package stt_pkg;

   localparam int LINE_BITS = 16;
   localparam int COL_BITS = 16;
   localparam int LENGTH_BITS = 16;
   localparam int KEYWORD_MAX_LEN = 6;
   localparam int KW_IDX_BITS = $clog2(KEYWORD_MAX_LEN);
   localparam int KW_COUNT = 9;

   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_MAX_PER_ITEM = 4;

   localparam logic [5:0] KIND_IDENT = 6'd9;
   localparam logic [5:0] KIND_NUMBER = 6'd10;
   localparam logic [5:0] KIND_STRING = 6'd11;
   localparam logic [5:0] KIND_EOF = 6'd34;
   localparam logic [5:0] KIND_NONE = 6'd0;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_UNCLOSED = 2'd1;
   localparam logic [1:0] ERR_ESCAPE = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_DOT = 8'h2e;
   localparam logic [7:0] CH_UNDER = 8'h5f;

   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      "var   ", "print ", "if    ", "else  ", "while ",
      "true  ", "false ", "fun   ", "return"
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd4, 4'd5, 4'd3, 4'd6
   };

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_NUM_INT,
      MODE_NUM_FRAC,
      MODE_IDENT,
      MODE_STR,
      MODE_ESC,
      MODE_COMMENT,
      MODE_ENDED
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic [LINE_BITS-1:0] line;
      logic [COL_BITS-1:0] col;
      logic [LINE_BITS-1:0] tline;
      logic [COL_BITS-1:0] tcol;
      logic [LENGTH_BITS-1:0] tlen;
      logic [KEYWORD_MAX_LEN-1:0][7:0] kw;
      logic err;
   } lex_state_type;

   typedef struct packed {
      logic [5:0] kind;
      logic [15:0] line;
      logic [15:0] col;
      logic [7:0] vbyte;
      logic vvalid;
      logic done;
      logic [15:0] len;
      logic [1:0] err;
      logic last;
   } result_type;

   typedef struct packed {
      lex_state_type st;
      result_type [RSP_MAX_PER_ITEM-1:0] res;
      logic [2:0] n;
   } ctx_type;

   typedef struct packed {
      logic push;
      logic [2:0] count;
   } push_ctl_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic has,
                                            input logic [7:0] nx);
      logic [5:0] k;
      k = KIND_NONE;
      if (has) begin
         if (h == "=" && nx == "=") k = 6'd12;
         else if (h == "!" && nx == "=") k = 6'd13;
         else if (h == "<" && nx == "=") k = 6'd14;
         else if (h == ">" && nx == "=") k = 6'd15;
         else if (h == "&" && nx == "&") k = 6'd16;
         else if (h == "|" && nx == "|") k = 6'd17;
      end
      return k;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] h);
      logic [5:0] k;
      case (h)
         "+": k = 6'd18;
         "-": k = 6'd19;
         "*": k = 6'd20;
         "/": k = 6'd21;
         "=": k = 6'd22;
         "<": k = 6'd23;
         ">": k = 6'd24;
         "!": k = 6'd25;
         "(": k = 6'd26;
         ")": k = 6'd27;
         "{": k = 6'd28;
         "}": k = 6'd29;
         "[": k = 6'd30;
         "]": k = 6'd31;
         ";": k = 6'd32;
         ",": k = 6'd33;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic ctx_type put_res(input ctx_type c, input logic [5:0] kind,
                                       input logic [15:0] ln, input logic [15:0] cl,
                                       input logic [7:0] vb, input logic vv,
                                       input logic dn, input logic [15:0] len,
                                       input logic [1:0] ec);
      if (c.n < 3'(RSP_MAX_PER_ITEM)) begin
         c.res[c.n[1:0]].kind = kind;
         c.res[c.n[1:0]].line = ln;
         c.res[c.n[1:0]].col = cl;
         c.res[c.n[1:0]].vbyte = vb;
         c.res[c.n[1:0]].vvalid = vv;
         c.res[c.n[1:0]].done = dn;
         c.res[c.n[1:0]].len = len;
         c.res[c.n[1:0]].err = ec;
         c.res[c.n[1:0]].last = 1'b0;
         c.n = c.n + 3'd1;
      end
      return c;
   endfunction

   function automatic ctx_type consume(input ctx_type c, input logic [7:0] ch);
      if (ch == CH_LF) begin
         if (c.st.line != '1) c.st.line = c.st.line + 1'b1;
         c.st.col = COL_BITS'(1);
      end else if (c.st.col != '1) begin
         c.st.col = c.st.col + 1'b1;
      end
      return c;
   endfunction

   function automatic ctx_type emit_value(input ctx_type c, input logic [7:0] v,
                                          input logic dn, input logic [5:0] kind);
      if (c.st.tlen != '1) c.st.tlen = c.st.tlen + 1'b1;
      if (dn) begin
         c = put_res(c, kind, 16'(c.st.tline), 16'(c.st.tcol), v, 1'b1, 1'b1,
                     16'(c.st.tlen), ERR_NONE);
         c.st.mode = MODE_IDLE;
      end else begin
         c = put_res(c, KIND_NONE, 16'(c.st.tline), 16'(c.st.tcol), v, 1'b1, 1'b0,
                     16'd0, ERR_NONE);
      end
      return c;
   endfunction

   function automatic ctx_type emit_done(input ctx_type c, input logic [5:0] kind);
      c = put_res(c, kind, 16'(c.st.tline), 16'(c.st.tcol), 8'd0, 1'b0, 1'b1,
                  16'(c.st.tlen), ERR_NONE);
      c.st.mode = MODE_IDLE;
      return c;
   endfunction

   function automatic ctx_type fail(input ctx_type c, input logic [1:0] code);
      c = put_res(c, KIND_NONE, 16'(c.st.line), 16'(c.st.col), 8'd0, 1'b0, 1'b0,
                  16'd0, code);
      c.st.err = 1'b1;
      return c;
   endfunction

   function automatic logic [5:0] word_kind(input lex_state_type s);
      logic [5:0] k;
      logic hit;
      k = KIND_IDENT;
      if (s.tlen <= LENGTH_BITS'(KEYWORD_MAX_LEN)) begin
         for (int i = KW_COUNT - 1; i >= 0; i--) begin
            hit = (s.tlen == LENGTH_BITS'(KW_LEN[i]));
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
               if (j < int'(KW_LEN[i]) && s.kw[j] != KW_TEXT[i][8*(5-j) +: 8]) hit = 1'b0;
            end
            if (hit) k = 6'(i);
         end
      end
      return k;
   endfunction

   function automatic ctx_type string_value(input ctx_type c, input logic [7:0] v,
                                            input logic [7:0] h, input logic [7:0] nx,
                                            input logic has, output logic used);
      c.st.mode = MODE_STR;
      if (has && nx == CH_QUOTE) begin
         c = emit_value(c, v, 1'b1, KIND_STRING);
         c = consume(c, h);
         c = consume(c, nx);
         used = 1'b1;
      end else begin
         c = emit_value(c, v, 1'b0, KIND_NONE);
         c = consume(c, h);
         used = 1'b0;
      end
      return c;
   endfunction

   function automatic ctx_type lex_process(input ctx_type c0, input logic [7:0] h,
                                           input logic [7:0] nx, input logic has,
                                           output logic used);
      ctx_type c;
      logic go;
      logic more;
      logic [5:0] k;
      logic u;
      c = c0;
      used = 1'b0;
      go = 1'b1;
      for (int p = 0; p < 3; p++) begin
         if (go) begin
            go = 1'b0;
            unique case (c.st.mode)
               MODE_IDLE: begin
                  if (is_space(h)) begin
                     c = consume(c, h);
                  end else begin
                     c.st.tline = c.st.line;
                     c.st.tcol = c.st.col;
                     c.st.tlen = '0;
                     if (is_digit(h)) begin
                        c.st.mode = MODE_NUM_INT;
                        go = 1'b1;
                     end else if (is_alpha(h) || h == CH_UNDER) begin
                        c.st.mode = MODE_IDENT;
                        go = 1'b1;
                     end else if (h == CH_QUOTE) begin
                        c = consume(c, h);
                        c.st.mode = MODE_STR;
                     end else if (h == CH_SLASH && has && nx == CH_SLASH) begin
                        c = consume(c, h);
                        c.st.mode = MODE_COMMENT;
                     end else if (pair_kind(h, has, nx) != KIND_NONE) begin
                        k = pair_kind(h, has, nx);
                        c = emit_value(c, h, 1'b0, KIND_NONE);
                        c = consume(c, h);
                        c = emit_value(c, nx, 1'b1, k);
                        c = consume(c, nx);
                        used = 1'b1;
                     end else if (single_kind(h) != KIND_NONE) begin
                        c = emit_value(c, h, 1'b1, single_kind(h));
                        c = consume(c, h);
                     end else begin
                        c = fail(c, ERR_UNEXPECTED);
                     end
                  end
               end
               MODE_NUM_INT: begin
                  if (is_digit(h)) begin
                     more = has && (is_digit(nx) || nx == CH_DOT);
                     c = emit_value(c, h, !more, KIND_NUMBER);
                     c = consume(c, h);
                  end else if (h == CH_DOT && has && is_digit(nx)) begin
                     c = emit_value(c, h, 1'b0, KIND_NONE);
                     c = consume(c, h);
                     c.st.mode = MODE_NUM_FRAC;
                  end else begin
                     c = emit_done(c, KIND_NUMBER);
                     go = 1'b1;
                  end
               end
               MODE_NUM_FRAC: begin
                  if (is_digit(h)) begin
                     c = emit_value(c, h, !(has && is_digit(nx)), KIND_NUMBER);
                     c = consume(c, h);
                  end else begin
                     c = emit_done(c, KIND_NUMBER);
                     go = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (is_word(h)) begin
                     more = has && is_word(nx);
                     if (c.st.tlen < LENGTH_BITS'(KEYWORD_MAX_LEN))
                        c.st.kw[c.st.tlen[KW_IDX_BITS-1:0]] = h;
                     if (more) begin
                        c = emit_value(c, h, 1'b0, KIND_NONE);
                     end else begin
                        if (c.st.tlen != '1) c.st.tlen = c.st.tlen + 1'b1;
                        c = put_res(c, word_kind(c.st), 16'(c.st.tline), 16'(c.st.tcol),
                                    h, 1'b1, 1'b1, 16'(c.st.tlen), ERR_NONE);
                        c.st.mode = MODE_IDLE;
                     end
                     c = consume(c, h);
                  end else begin
                     c = emit_done(c, KIND_IDENT);
                     go = 1'b1;
                  end
               end
               MODE_STR: begin
                  if (h == CH_QUOTE) begin
                     c = consume(c, h);
                     c = emit_done(c, KIND_STRING);
                  end else if (h == CH_LF) begin
                     c = fail(c, ERR_UNCLOSED);
                  end else if (h == CH_BSLASH) begin
                     c = consume(c, h);
                     c.st.mode = MODE_ESC;
                  end else begin
                     c = string_value(c, h, h, nx, has, u);
                     used = u;
                  end
               end
               MODE_ESC: begin
                  if (h == "n") begin
                     c = string_value(c, CH_LF, h, nx, has, u);
                     used = u;
                  end else if (h == "t") begin
                     c = string_value(c, CH_TAB, h, nx, has, u);
                     used = u;
                  end else if (h == CH_QUOTE || h == CH_BSLASH) begin
                     c = string_value(c, h, h, nx, has, u);
                     used = u;
                  end else begin
                     c = fail(c, ERR_ESCAPE);
                  end
               end
               MODE_COMMENT: begin
                  c = consume(c, h);
                  if (h == CH_LF) c.st.mode = MODE_IDLE;
               end
               default: begin
               end
            endcase
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[rtl/core/stt_rsp_queue.sv]
// Result queue that takes up to four results per cycle and hands out one per transfer.
`default_nettype none
module stt_rsp_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire stt_pkg::push_ctl_type push_ctl,
   input  wire stt_pkg::result_type [stt_pkg::RSP_MAX_PER_ITEM-1:0] push_items,
   input  wire logic pop,
   output stt_pkg::result_type head,
   output logic head_valid,
   output logic room
);
   stt_pkg::result_type mem_ff [stt_pkg::RSP_DEPTH];
   logic [stt_pkg::RSP_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [stt_pkg::RSP_PTR_BITS:0] count_ff, count_in;
   logic do_pop;
   logic [2:0] added;

   assign head_valid = count_ff != '0;
   assign head = mem_ff[rd_ff];
   assign room = count_ff <= (stt_pkg::RSP_PTR_BITS+1)'(stt_pkg::RSP_DEPTH
                                                       - stt_pkg::RSP_MAX_PER_ITEM);
   assign do_pop = pop && head_valid;

   always_comb begin
      added = push_ctl.push ? push_ctl.count : 3'd0;
      wr_in = wr_ff + stt_pkg::RSP_PTR_BITS'(added);
      rd_in = rd_ff + stt_pkg::RSP_PTR_BITS'(do_pop);
      count_in = count_ff + (stt_pkg::RSP_PTR_BITS+1)'(added)
                 - (stt_pkg::RSP_PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < stt_pkg::RSP_MAX_PER_ITEM; i++) begin
         if (push_ctl.push && 3'(i) < push_ctl.count)
            mem_ff[wr_ff + stt_pkg::RSP_PTR_BITS'(i)] <= push_items[i];
      end
   end
endmodule
`default_nettype wire

[rtl/core/source_text_tokenizer_top.sv]
// Top level of the source text tokenizer.
// A byte is held until the next byte or end of source decides it; results queue for rsp_.
// One byte is accepted per cycle while the result queue has room for four more results.
// Results leave one per cycle while rsp_ready is high; bytes with many results slow intake.
// Synchronous reset returns the lexer to idle at line 1, column 1 and empties the queue.
`default_nettype none
module source_text_tokenizer_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic req_byte_present,
   input  wire logic req_end_of_source,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [5:0] rsp_token_kind,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_col,
   output logic [7:0] rsp_value_byte,
   output logic rsp_value_valid,
   output logic rsp_token_done,
   output logic [15:0] rsp_value_length,
   output logic [1:0] rsp_error_code,
   output logic rsp_last_result
);
   logic in_valid_ff;
   logic [7:0] in_byte_ff;
   logic in_present_ff, in_eos_ff;
   stt_pkg::lex_state_type state_ff;
   logic [7:0] held_ff, held_in;
   logic held_valid_ff, held_valid_in;
   stt_pkg::ctx_type ctx;
   stt_pkg::push_ctl_type push_ctl;
   stt_pkg::result_type head;
   logic room, fire, used_a, used_b;

   assign fire = in_valid_ff && room;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_present_ff <= req_byte_present;
         in_eos_ff <= req_end_of_source;
      end
   end

   always_comb begin
      ctx.st = state_ff;
      ctx.res = '0;
      ctx.n = 3'd0;
      held_in = held_ff;
      held_valid_in = held_valid_ff;
      used_a = 1'b0;
      used_b = 1'b0;
      if (!(state_ff.err || state_ff.mode == stt_pkg::MODE_ENDED)) begin
         if (in_present_ff) begin
            if (held_valid_ff) begin
               ctx = stt_pkg::lex_process(ctx, held_ff, in_byte_ff, 1'b1, used_a);
               held_valid_in = 1'b0;
               if (!used_a && !ctx.st.err) begin
                  held_in = in_byte_ff;
                  held_valid_in = 1'b1;
               end
            end else begin
               held_in = in_byte_ff;
               held_valid_in = 1'b1;
            end
         end
         if (in_eos_ff && !ctx.st.err) begin
            if (held_valid_in) begin
               held_valid_in = 1'b0;
               ctx = stt_pkg::lex_process(ctx, held_in, 8'd0, 1'b0, used_b);
            end
            if (!ctx.st.err) begin
               if (ctx.st.mode == stt_pkg::MODE_STR) begin
                  ctx = stt_pkg::fail(ctx, stt_pkg::ERR_UNCLOSED);
               end else if (ctx.st.mode == stt_pkg::MODE_ESC) begin
                  ctx = stt_pkg::fail(ctx, stt_pkg::ERR_ESCAPE);
               end else begin
                  ctx = stt_pkg::put_res(ctx, stt_pkg::KIND_EOF, 16'(ctx.st.line),
                                         16'(ctx.st.col), 8'd0, 1'b0, 1'b1, 16'd0,
                                         stt_pkg::ERR_NONE);
                  ctx.st.mode = stt_pkg::MODE_ENDED;
               end
            end
         end
      end
      if (ctx.n != 3'd0) ctx.res[ctx.n[1:0] - 2'd1].last = 1'b1;
      push_ctl.push = fire;
      push_ctl.count = ctx.n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode <= stt_pkg::MODE_IDLE;
         state_ff.line <= stt_pkg::LINE_BITS'(1);
         state_ff.col <= stt_pkg::COL_BITS'(1);
         state_ff.tline <= stt_pkg::LINE_BITS'(1);
         state_ff.tcol <= stt_pkg::COL_BITS'(1);
         state_ff.tlen <= '0;
         state_ff.kw <= '0;
         state_ff.err <= 1'b0;
         held_ff <= 8'd0;
         held_valid_ff <= 1'b0;
      end else if (fire) begin
         state_ff <= ctx.st;
         held_ff <= held_in;
         held_valid_ff <= held_valid_in;
      end
   end

   stt_rsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_ctl(push_ctl),
      .push_items(ctx.res),
      .pop(rsp_ready),
      .head(head),
      .head_valid(rsp_valid),
      .room(room)
   );

   assign rsp_token_kind = head.kind;
   assign rsp_start_line = head.line;
   assign rsp_start_col = head.col;
   assign rsp_value_byte = head.vbyte;
   assign rsp_value_valid = head.vvalid;
   assign rsp_token_done = head.done;
   assign rsp_value_length = head.len;
   assign rsp_error_code = head.err;
   assign rsp_last_result = head.last;
endmodule
`default_nettype wire

[rtl/core/stt_checker.sv]
// Port-level assertions for the source text tokenizer, bound to its top level.
`default_nettype none
module stt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [5:0] rsp_token_kind,
   input wire logic [7:0] rsp_value_byte,
   input wire logic rsp_value_valid,
   input wire logic rsp_token_done,
   input wire logic [15:0] rsp_value_length,
   input wire logic [1:0] rsp_error_code,
   input wire logic rsp_last_result
);
   a_no_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_valid |-> rsp_value_byte == 8'd0)
      else $error("value byte set without value valid");

   a_partial_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_token_done |-> rsp_token_kind == stt_pkg::KIND_NONE
                                       && rsp_value_length == 16'd0)
      else $error("partial result carries kind or length");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != stt_pkg::ERR_NONE |-> rsp_last_result && !rsp_token_done)
      else $error("error result is not the final one");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
                                  && $stable(rsp_value_byte))
      else $error("stalled transfer changed");
endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the source text tokenizer: byte stream in, token results out.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 460;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [5:0] PAIR_BASE = 6'd12;
   localparam logic [5:0] SINGLE_BASE = 6'd18;

   string kw_words[9] = '{"var", "print", "if", "else", "while", "true", "false", "fun",
                          "return"};
   string op_words[22] = '{"==", "!=", "<=", ">=", "&&", "||", "+", "-", "*", "/", "=", "<",
                           ">", "!", "(", ")", "{", "}", "[", "]", ";", ","};
   string single_ops = "+-*/=<>!(){}[];,";

   class lexer_scoreboard_type;
      stt_pkg::mode_type mode;
      logic [7:0] held;
      bit held_ok;
      logic [15:0] line, col, tline, tcol, tlen;
      logic [7:0] kw [6];
      bit err;
      stt_pkg::result_type step_res[$];
      stt_pkg::result_type pending[$];
      int fails;

      function new();
         mode = stt_pkg::MODE_IDLE;
         held = 8'd0;
         held_ok = 1'b0;
         line = 16'd1;
         col = 16'd1;
         tline = 16'd1;
         tcol = 16'd1;
         tlen = 16'd0;
         foreach (kw[i]) kw[i] = 8'd0;
         err = 1'b0;
         fails = 0;
      endfunction

      function logic [15:0] sat(logic [15:0] v);
         return (v == 16'hffff) ? v : v + 16'd1;
      endfunction

      function bit digit_ch(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit letter_ch(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit word_ch(logic [7:0] c);
         return letter_ch(c) || digit_ch(c) || c == stt_pkg::CH_UNDER;
      endfunction

      function bit blank_ch(logic [7:0] c);
         return c == " " || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function void advance(logic [7:0] c);
         if (c == stt_pkg::CH_LF) begin
            line = sat(line);
            col = 16'd1;
         end else begin
            col = sat(col);
         end
      endfunction

      function void put(logic [5:0] kind, logic [15:0] ln, logic [15:0] cl, logic [7:0] vb,
                        bit vv, bit dn, logic [15:0] len, logic [1:0] ec);
         stt_pkg::result_type r;
         if (step_res.size() < stt_pkg::RSP_MAX_PER_ITEM) begin
            r.kind = kind;
            r.line = ln;
            r.col = cl;
            r.vbyte = vb;
            r.vvalid = vv;
            r.done = dn;
            r.len = len;
            r.err = ec;
            r.last = 1'b0;
            step_res.insert(step_res.size(), r);
         end
      endfunction

      function void add_value(logic [7:0] v, bit dn, logic [5:0] kind);
         tlen = sat(tlen);
         if (dn) begin
            put(kind, tline, tcol, v, 1'b1, 1'b1, tlen, stt_pkg::ERR_NONE);
            mode = stt_pkg::MODE_IDLE;
         end else begin
            put(stt_pkg::KIND_NONE, tline, tcol, v, 1'b1, 1'b0, 16'd0, stt_pkg::ERR_NONE);
         end
      endfunction

      function void close_token(logic [5:0] kind);
         put(kind, tline, tcol, 8'd0, 1'b0, 1'b1, tlen, stt_pkg::ERR_NONE);
         mode = stt_pkg::MODE_IDLE;
      endfunction

      function void raise_error(logic [1:0] code);
         put(stt_pkg::KIND_NONE, line, col, 8'd0, 1'b0, 1'b0, 16'd0, code);
         err = 1'b1;
      endfunction

      function logic [5:0] keyword_kind();
         bit hit;
         if (tlen > 16'd6) return stt_pkg::KIND_IDENT;
         for (int i = 0; i < 9; i++) begin
            hit = (kw_words[i].len() == int'(tlen));
            for (int j = 0; j < kw_words[i].len(); j++)
               if (kw[j] != kw_words[i][j]) hit = 1'b0;
            if (hit) return 6'(i);
         end
         return stt_pkg::KIND_IDENT;
      endfunction

      function logic [5:0] pair_code(logic [7:0] h, bit has, logic [7:0] nx);
         if (!has) return stt_pkg::KIND_NONE;
         for (int i = 0; i < 6; i++)
            if (h == op_words[i][0] && nx == op_words[i][1]) return PAIR_BASE + 6'(i);
         return stt_pkg::KIND_NONE;
      endfunction

      function logic [5:0] single_code(logic [7:0] h);
         for (int i = 0; i < 16; i++)
            if (h == single_ops[i]) return SINGLE_BASE + 6'(i);
         return stt_pkg::KIND_NONE;
      endfunction

      function bit string_byte(logic [7:0] v, logic [7:0] h, logic [7:0] nx, bit has);
         mode = stt_pkg::MODE_STR;
         if (has && nx == stt_pkg::CH_QUOTE) begin
            add_value(v, 1'b1, stt_pkg::KIND_STRING);
            advance(h);
            advance(nx);
            return 1'b1;
         end
         add_value(v, 1'b0, stt_pkg::KIND_NONE);
         advance(h);
         return 1'b0;
      endfunction

      // Decides the held byte h with lookahead nx; returns 1 when nx was used up.
      function bit decide(logic [7:0] h, logic [7:0] nx, bit has);
         bit go;
         bit used;
         bit more;
         logic [5:0] k;
         used = 1'b0;
         go = 1'b1;
         while (go) begin
            go = 1'b0;
            case (mode)
               stt_pkg::MODE_IDLE: begin
                  if (blank_ch(h)) begin
                     advance(h);
                  end else begin
                     tline = line;
                     tcol = col;
                     tlen = 16'd0;
                     if (digit_ch(h)) begin
                        mode = stt_pkg::MODE_NUM_INT;
                        go = 1'b1;
                     end else if (letter_ch(h) || h == stt_pkg::CH_UNDER) begin
                        mode = stt_pkg::MODE_IDENT;
                        go = 1'b1;
                     end else if (h == stt_pkg::CH_QUOTE) begin
                        advance(h);
                        mode = stt_pkg::MODE_STR;
                     end else if (h == stt_pkg::CH_SLASH && has && nx == stt_pkg::CH_SLASH) begin
                        advance(h);
                        mode = stt_pkg::MODE_COMMENT;
                     end else begin
                        k = pair_code(h, has, nx);
                        if (k != stt_pkg::KIND_NONE) begin
                           add_value(h, 1'b0, stt_pkg::KIND_NONE);
                           advance(h);
                           add_value(nx, 1'b1, k);
                           advance(nx);
                           used = 1'b1;
                        end else begin
                           k = single_code(h);
                           if (k != stt_pkg::KIND_NONE) begin
                              add_value(h, 1'b1, k);
                              advance(h);
                           end else begin
                              raise_error(stt_pkg::ERR_UNEXPECTED);
                           end
                        end
                     end
                  end
               end
               stt_pkg::MODE_NUM_INT: begin
                  if (digit_ch(h)) begin
                     more = has && (digit_ch(nx) || nx == stt_pkg::CH_DOT);
                     add_value(h, !more, stt_pkg::KIND_NUMBER);
                     advance(h);
                  end else if (h == stt_pkg::CH_DOT && has && digit_ch(nx)) begin
                     add_value(h, 1'b0, stt_pkg::KIND_NONE);
                     advance(h);
                     mode = stt_pkg::MODE_NUM_FRAC;
                  end else begin
                     close_token(stt_pkg::KIND_NUMBER);
                     go = 1'b1;
                  end
               end
               stt_pkg::MODE_NUM_FRAC: begin
                  if (digit_ch(h)) begin
                     add_value(h, !(has && digit_ch(nx)), stt_pkg::KIND_NUMBER);
                     advance(h);
                  end else begin
                     close_token(stt_pkg::KIND_NUMBER);
                     go = 1'b1;
                  end
               end
               stt_pkg::MODE_IDENT: begin
                  if (word_ch(h)) begin
                     more = has && word_ch(nx);
                     if (tlen < 16'd6) kw[tlen[2:0]] = h;
                     if (more) begin
                        add_value(h, 1'b0, stt_pkg::KIND_NONE);
                     end else begin
                        tlen = sat(tlen);
                        put(keyword_kind(), tline, tcol, h, 1'b1, 1'b1, tlen,
                            stt_pkg::ERR_NONE);
                        mode = stt_pkg::MODE_IDLE;
                     end
                     advance(h);
                  end else begin
                     close_token(stt_pkg::KIND_IDENT);
                     go = 1'b1;
                  end
               end
               stt_pkg::MODE_STR: begin
                  if (h == stt_pkg::CH_QUOTE) begin
                     advance(h);
                     close_token(stt_pkg::KIND_STRING);
                  end else if (h == stt_pkg::CH_LF) begin
                     raise_error(stt_pkg::ERR_UNCLOSED);
                  end else if (h == stt_pkg::CH_BSLASH) begin
                     advance(h);
                     mode = stt_pkg::MODE_ESC;
                  end else begin
                     used = string_byte(h, h, nx, has);
                  end
               end
               stt_pkg::MODE_ESC: begin
                  if (h == "n") used = string_byte(stt_pkg::CH_LF, h, nx, has);
                  else if (h == "t") used = string_byte(stt_pkg::CH_TAB, h, nx, has);
                  else if (h == stt_pkg::CH_QUOTE || h == stt_pkg::CH_BSLASH)
                     used = string_byte(h, h, nx, has);
                  else raise_error(stt_pkg::ERR_ESCAPE);
               end
               stt_pkg::MODE_COMMENT: begin
                  advance(h);
                  if (h == stt_pkg::CH_LF) mode = stt_pkg::MODE_IDLE;
               end
               default: begin
               end
            endcase
         end
         return used;
      endfunction

      function void note_input(logic [7:0] b, bit present, bit eos);
         bit used;
         step_res.delete();
         if (err || mode == stt_pkg::MODE_ENDED) return;
         if (present) begin
            if (held_ok) begin
               used = decide(held, b, 1'b1);
               held_ok = 1'b0;
               if (!used && !err) begin
                  held = b;
                  held_ok = 1'b1;
               end
            end else begin
               held = b;
               held_ok = 1'b1;
            end
         end
         if (eos && !err) begin
            if (held_ok) begin
               held_ok = 1'b0;
               void'(decide(held, 8'd0, 1'b0));
            end
            if (!err) begin
               if (mode == stt_pkg::MODE_STR) raise_error(stt_pkg::ERR_UNCLOSED);
               else if (mode == stt_pkg::MODE_ESC) raise_error(stt_pkg::ERR_ESCAPE);
               else begin
                  put(stt_pkg::KIND_EOF, line, col, 8'd0, 1'b0, 1'b1, 16'd0,
                      stt_pkg::ERR_NONE);
                  mode = stt_pkg::MODE_ENDED;
               end
            end
         end
         if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
         foreach (step_res[i]) pending.insert(pending.size(), step_res[i]);
      endfunction

      function void check_result(stt_pkg::result_type got);
         stt_pkg::result_type want;
         if (pending.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected result transfer: %p", got);
            return;
         end
         want = pending.pop_front();
         if (want !== got) begin
            fails++;
            if (fails <= 10)
               $display({"mismatch: kind %0d/%0d line %0d/%0d col %0d/%0d byte %0h/%0h ",
                         "vvalid %0b/%0b done %0b/%0b len %0d/%0d err %0d/%0d last %0b/%0b",
                         " (expected/actual)"},
                        want.kind, got.kind, want.line, got.line, want.col, got.col,
                        want.vbyte, got.vbyte, want.vvalid, got.vvalid, want.done, got.done,
                        want.len, got.len, want.err, got.err, want.last, got.last);
         end
      endfunction
   endclass

   typedef struct {
      logic [7:0] b;
      bit p;
      bit e;
   } src_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_in_byte = 8'd0;
   logic req_byte_present = 1'b0;
   logic req_end_of_source = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_token_kind;
   logic [15:0] rsp_start_line, rsp_start_col, rsp_value_length;
   logic [7:0] rsp_value_byte;
   logic rsp_value_valid, rsp_token_done, rsp_last_result;
   logic [1:0] rsp_error_code;
   stt_pkg::result_type rsp_seen;

   lexer_scoreboard_type sb = new();
   src_item_type stim[$];
   bit hold_go = 1'b0;
   int idle_cycles = 0;

   source_text_tokenizer_top dut (.*);

   assign rsp_seen = {rsp_token_kind, rsp_start_line, rsp_start_col, rsp_value_byte,
                      rsp_value_valid, rsp_token_done, rsp_value_length, rsp_error_code,
                      rsp_last_result};

   initial begin
      forever #10 clock = ~clock;
   end

   function void stim_add(logic [7:0] b, bit p, bit e);
      src_item_type it;
      it.b = b;
      it.p = p;
      it.e = e;
      stim.insert(stim.size(), it);
   endfunction

   function void push_byte(logic [7:0] b);
      stim_add(b, 1'b1, 1'b0);
   endfunction

   function void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == stt_pkg::CH_QUOTE || b == stt_pkg::CH_BSLASH || b == stt_pkg::CH_LF);
      return b;
   endfunction

   function void push_token();
      int n;
      string esc;
      case ($urandom_range(0, 9))
         0, 1: push_text(kw_words[$urandom_range(0, 8)]);
         2: begin
            n = $urandom_range(0, 9);
            push_byte(($urandom_range(0, 3) == 0) ? stt_pkg::CH_UNDER :
                      8'("a" + $urandom_range(0, 25)) - ($urandom_range(0, 1) ? 8'd32 : 8'd0));
            for (int i = 0; i < n; i++)
               case ($urandom_range(0, 3))
                  0: push_byte(8'("0" + $urandom_range(0, 9)));
                  1: push_byte(stt_pkg::CH_UNDER);
                  2: push_byte(8'("A" + $urandom_range(0, 25)));
                  default: push_byte(8'("a" + $urandom_range(0, 25)));
               endcase
         end
         3: begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
               push_byte(stt_pkg::CH_DOT);
               n = $urandom_range(1, 3);
               for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
            end
         end
         4: begin
            esc = "nt\"\\";
            push_byte(stt_pkg::CH_QUOTE);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
               if ($urandom_range(0, 3) == 0) begin
                  push_byte(stt_pkg::CH_BSLASH);
                  push_byte(esc[$urandom_range(0, 3)]);
               end else begin
                  push_byte(plain_byte());
               end
            push_byte(stt_pkg::CH_QUOTE);
         end
         5, 6: push_text(op_words[$urandom_range(0, 21)]);
         7: begin
            push_text("//");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) push_byte(plain_byte());
            push_byte(stt_pkg::CH_LF);
         end
         8: stim_add(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         default: begin
            push_text(op_words[$urandom_range(6, 21)]);
            push_byte(8'("0" + $urandom_range(0, 9)));
         end
      endcase
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++)
         case ($urandom_range(0, 5))
            0: push_byte(stt_pkg::CH_TAB);
            1: push_byte(stt_pkg::CH_LF);
            2: push_byte(8'($urandom_range(11, 13)));
            default: push_byte(" ");
         endcase
   endfunction

   function void push_ending();
      case ($urandom_range(0, 5))
         0: stim_add(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         1: begin
            push_text("end");
            stim[stim.size()-1].e = 1'b1;
         end
         2: begin
            push_text("\"a");
            if ($urandom_range(0, 1)) push_byte(stt_pkg::CH_LF);
            else stim[stim.size()-1].e = 1'b1;
         end
         3: begin
            push_text("\"\\");
            if ($urandom_range(0, 1)) push_byte("q");
            else stim[stim.size()-1].e = 1'b1;
         end
         4: push_text("5. ");
         default: begin
            case ($urandom_range(0, 3))
               0: push_byte("#");
               1: push_byte(8'h00);
               2: push_byte(8'($urandom_range(128, 255)));
               default: push_text("& ");
            endcase
            push_byte(" ");
         end
      endcase
      for (int i = 0; i < 5; i++)
         stim_add(8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom));
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_seen);
         if (req_valid && req_ready)
            sb.note_input(req_in_byte, req_byte_present, req_end_of_source);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL source_text_tokenizer_top");
            $finish;
         end
      end
   end

   initial begin
      int stall_mode;
      bit hold_done;
      hold_done = 1'b0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      int burst_left;
      int gap;
      burst_left = 0;
      push_text("Ab_9 0.25 \"\\t\\\"\\\\\"\"\" x>=-7;//");
      push_byte(8'hff);
      push_byte(8'h00);
      push_byte(stt_pkg::CH_LF);
      while (stim.size() < ITEM_TARGET) push_token();
      push_ending();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (stim[i]) begin
         if (i == 150) hold_go = 1'b1;
         if (i == 300) begin
            while (sb.pending.size() != 0) begin
               req_valid <= 1'b0;
               @(posedge clock);
            end
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_valid <= 1'b1;
         req_in_byte <= stim[i].b;
         req_byte_present <= stim[i].p;
         req_end_of_source <= stim[i].e;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         burst_left--;
      end
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.fails == 0 && sb.pending.size() == 0) begin
         $display("PASS source_text_tokenizer_top");
      end else begin
         $display("FAIL source_text_tokenizer_top");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
rtl/core/stt_pkg.sv
rtl/core/stt_rsp_queue.sv
rtl/core/source_text_tokenizer_top.sv
rtl/core/stt_checker.sv
tb/tb_top.sv
